[rtl/tws_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tws_pkg
// Types, codes and helper functions shared by the two-wire sensor master.
// ----------------------------------------------------------------------------
package tws_pkg;

   // Sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CLEAR,
      PH_START,
      PH_CMD,
      PH_CACK,
      PH_WAIT,
      PH_DHI,
      PH_DLO,
      PH_CRC
   } phase_type;

   // Completion status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NACK    = 2'd1,
      ST_CRC_ERR = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   // Command selector codes on the input item
   localparam logic [1:0] CMD_TEMP   = 2'd0;
   localparam logic [1:0] CMD_HUMID  = 2'd1;
   localparam logic [1:0] CMD_SRESET = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Command bytes sent on the wire
   localparam logic [7:0] CODE_TEMP   = 8'h03;
   localparam logic [7:0] CODE_HUMID  = 8'h05;
   localparam logic [7:0] CODE_SRESET = 8'h1E;

   // CRC-8 polynomial x^8 + x^5 + x^4 + 1
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Step counts of each phase
   localparam logic [4:0] CLEAR_STEPS    = 5'd20;
   localparam logic [4:0] START_STEPS    = 5'd6;
   localparam logic [4:0] CMD_STEPS      = 5'd16;
   localparam logic [4:0] BYTE_BITS_END  = 5'd16;
   localparam logic [4:0] BYTE_LAST_STEP = 5'd15;
   localparam logic [4:0] BYTE_END_STEP  = 5'd17;

   // Register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_TIMEOUT = 1'b0;
   localparam logic [23:0] TIMEOUT_RESET = 24'd500000;

   // Input item fields
   typedef struct packed {
      logic       func;
      logic [1:0] command;
      logic       sda_in;
   } req_type;

   // Result item fields
   typedef struct packed {
      logic        scl_out;
      logic        sda_drive_low;
      logic        busy_res;
      logic        done_res;
      logic [1:0]  status;
      logic [15:0] reading;
   } rsp_type;

   // Map a held command selector to its wire byte
   function automatic logic [7:0] cmd_code(input logic [1:0] sel);
      logic [7:0] code;
      case (sel)
         CMD_TEMP:  code = CODE_TEMP;
         CMD_HUMID: code = CODE_HUMID;
         default:   code = CODE_SRESET;
      endcase
      return code;
   endfunction

   // Fold one byte into the CRC, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      c = crc;
      d = data;
      for (int i = 0; i < 8; i++) begin
         if (c[7] ^ d[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
         d = {d[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/tws_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tws_req_if / tws_rsp_if
// Valid/ready channels for command and tick items and for result items.
// ----------------------------------------------------------------------------
interface tws_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [1:0] command;
   logic       sda_in;

   modport source (output valid, func, command, sda_in, input ready);
   modport sink   (input valid, func, command, sda_in, output ready);
endinterface

interface tws_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_out;
   logic        sda_drive_low;
   logic        busy_res;
   logic        done_res;
   logic [1:0]  status;
   logic [15:0] reading;

   modport source (output valid, scl_out, sda_drive_low, busy_res, done_res, status, reading,
                   input ready);
   modport sink   (input valid, scl_out, sda_drive_low, busy_res, done_res, status, reading,
                   output ready);
endinterface
`default_nettype wire

[rtl/two_wire_sensor_master_unit.sv]
// A result item is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle; the whole tick step is one pass of the
// sequencer logic between the state registers and the result register.
// A waiting result does not stall input unless the result side holds off.
// Reset (synchronous, active high): sequencer idle, result slot empty,
// ready timeout 500000 ticks.
`default_nettype none
// ----------------------------------------------------------------------------
// two_wire_sensor_master_unit
// Two-wire humidity and temperature sensor master, one tick per item.
// ----------------------------------------------------------------------------
module two_wire_sensor_master_unit
   import tws_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tws_req_if.sink                    req_chan,
   tws_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   logic [23:0] timeout_ticks;
   logic        accept;
   req_type     req;
   rsp_type     rsp_in;

   // Gather the input item fields
   assign req.func    = req_chan.func;
   assign req.command = req_chan.command;
   assign req.sda_in  = req_chan.sda_in;

   tws_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .timeout_ticks (timeout_ticks)
   );

   tws_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req),
      .timeout_ticks (timeout_ticks),
      .rsp_in        (rsp_in)
   );

   tws_out u_out (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .rsp_in   (rsp_in),
      .accept   (accept)
   );

endmodule
`default_nettype wire

[rtl/tws_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tws_csr
// APB-style register port holding the ready timeout.
// ----------------------------------------------------------------------------
module tws_csr
   import tws_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output logic      [23:0]           timeout_ticks
);

   logic [23:0] timeout_ff;
   logic [23:0] timeout_in;
   logic        wr_en;

   // Decode the word index from the byte address
   assign wr_en = csr_psel && csr_penable && csr_pwrite
                  && (csr_paddr[2] == REG_TIMEOUT);

   assign timeout_in = wr_en ? csr_pwdata[23:0] : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // Return the register, zero elsewhere
   assign csr_prdata    = (csr_paddr[2] == REG_TIMEOUT) ? {8'd0, timeout_ff} : 32'd0;
   assign csr_pready    = 1'b1;
   assign timeout_ticks = timeout_ff;

endmodule
`default_nettype wire

[rtl/tws_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tws_seq
// Transaction sequencer: pin levels, bit shifting, CRC and completion.
// ----------------------------------------------------------------------------
module tws_seq
   import tws_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire req_type     req,
   input  wire logic [23:0] timeout_ticks,
   output rsp_type          rsp_in
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  step_ff, step_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] data_ff, data_in;
   logic [23:0] wait_ff, wait_in;
   logic [1:0]  held_ff, held_in;

   logic        fin;
   status_type  fin_st;
   logic [23:0] wait_inc;
   logic [7:0]  code;
   logic        scl;
   logic        low;

   assign wait_inc = wait_ff + 24'd1;
   assign code     = cmd_code(held_ff);

   // Detect completion of the transaction on this tick
   always_comb begin
      fin    = 1'b0;
      fin_st = ST_OK;
      if (!req.func) begin
         case (phase_ff)
            PH_CACK: begin
               if (step_ff != 5'd0) begin
                  if (shift_ff[0]) begin
                     fin    = 1'b1;
                     fin_st = ST_NACK;
                  end else if (held_ff == CMD_SRESET) begin
                     fin    = 1'b1;
                     fin_st = ST_OK;
                  end
               end
            end
            PH_WAIT: begin
               if (req.sda_in && (wait_inc >= timeout_ticks)) begin
                  fin    = 1'b1;
                  fin_st = ST_TIMEOUT;
               end
            end
            PH_CRC: begin
               if (step_ff >= BYTE_END_STEP) begin
                  fin    = 1'b1;
                  fin_st = (shift_ff == crc_ff) ? ST_OK : ST_CRC_ERR;
               end
            end
            default: begin
               fin = 1'b0;
            end
         endcase
      end
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      crc_in   = crc_ff;
      data_in  = data_ff;
      wait_in  = wait_ff;
      held_in  = held_ff;
      if (phase_ff == PH_IDLE) begin
         // Start a transaction on a known command
         if (req.func && (req.command != CMD_UNUSED)) begin
            held_in  = req.command;
            crc_in   = crc8_update(8'd0, cmd_code(req.command));
            data_in  = 16'd0;
            shift_in = 8'd0;
            wait_in  = 24'd0;
            phase_in = PH_CLEAR;
            step_in  = 5'd0;
         end
      end else if (!req.func) begin
         case (phase_ff)
            PH_CLEAR: begin
               step_in = step_ff + 5'd1;
               if (step_in >= CLEAR_STEPS) begin
                  phase_in = PH_START;
                  step_in  = 5'd0;
               end
            end
            PH_START: begin
               step_in = step_ff + 5'd1;
               if (step_in >= START_STEPS) begin
                  phase_in = PH_CMD;
                  step_in  = 5'd0;
               end
            end
            PH_CMD: begin
               step_in = step_ff + 5'd1;
               if (step_in >= CMD_STEPS) begin
                  phase_in = PH_CACK;
                  step_in  = 5'd0;
               end
            end
            PH_CACK: begin
               if (step_ff == 5'd0) begin
                  shift_in = {7'd0, req.sda_in};
                  step_in  = 5'd1;
               end else if (!fin) begin
                  phase_in = PH_WAIT;
                  step_in  = 5'd0;
                  wait_in  = 24'd0;
               end
            end
            PH_WAIT: begin
               if (!req.sda_in) begin
                  phase_in = PH_DHI;
                  step_in  = 5'd0;
                  shift_in = 8'd0;
               end else begin
                  wait_in = wait_inc;
               end
            end
            PH_DHI, PH_DLO: begin
               // Shift in MSB first on the clock-low ticks
               if ((step_ff < BYTE_BITS_END) && !step_ff[0]) begin
                  shift_in = {shift_ff[6:0], req.sda_in};
               end
               if (step_ff == BYTE_LAST_STEP) begin
                  crc_in  = crc8_update(crc_ff, shift_ff);
                  data_in = {data_ff[7:0], shift_ff};
               end
               if (step_ff >= BYTE_END_STEP) begin
                  phase_in = (phase_ff == PH_DHI) ? PH_DLO : PH_CRC;
                  step_in  = 5'd0;
                  shift_in = 8'd0;
               end else begin
                  step_in = step_ff + 5'd1;
               end
            end
            PH_CRC: begin
               // Checksum arrives LSB first
               if ((step_ff < BYTE_BITS_END) && !step_ff[0]) begin
                  shift_in = {req.sda_in, shift_ff[7:1]};
               end
               if (step_ff < BYTE_END_STEP) begin
                  step_in = step_ff + 5'd1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               step_in  = 5'd0;
            end
         endcase
         if (fin) begin
            phase_in = PH_IDLE;
            step_in  = 5'd0;
         end
      end
   end

   // Pin levels for the current step
   always_comb begin
      scl = 1'b0;
      low = 1'b0;
      case (phase_ff)
         PH_CLEAR: begin
            scl = ~step_ff[0];
         end
         PH_START: begin
            scl = (step_ff != 5'd2) && (step_ff != 5'd5) && (step_ff < START_STEPS);
            low = (step_ff inside {[5'd1:5'd3]});
         end
         PH_CMD: begin
            scl = step_ff[0];
            low = ~code[3'd7 - step_ff[3:1]];
         end
         PH_CACK, PH_CRC: begin
            scl = step_ff[0];
         end
         PH_DHI, PH_DLO: begin
            scl = step_ff[0];
            low = (step_ff >= BYTE_BITS_END);
         end
         default: begin
            scl = 1'b0;
         end
      endcase
   end

   // Result item
   always_comb begin
      rsp_in = '0;
      if (phase_ff == PH_IDLE) begin
         rsp_in.busy_res = req.func && (req.command != CMD_UNUSED);
      end else begin
         rsp_in.scl_out       = scl;
         rsp_in.sda_drive_low = low;
         rsp_in.busy_res      = 1'b1;
         rsp_in.done_res      = fin;
         rsp_in.status        = fin ? fin_st : ST_OK;
         rsp_in.reading       = (fin && (fin_st == ST_OK) && (held_ff != CMD_SRESET))
                                ? data_ff : 16'd0;
      end
   end

   // Advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= 5'd0;
         shift_ff <= 8'd0;
         crc_ff   <= 8'd0;
         data_ff  <= 16'd0;
         wait_ff  <= 24'd0;
         held_ff  <= CMD_TEMP;
      end else if (accept) begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         shift_ff <= shift_in;
         crc_ff   <= crc_in;
         data_ff  <= data_in;
         wait_ff  <= wait_in;
         held_ff  <= held_in;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= CLEAR_STEPS)
      else $error("step count beyond the clearing length");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_in.done_res |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after completion");

   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_in.done_res |-> (rsp_in.status == ST_OK) && (rsp_in.reading == 16'd0))
      else $error("status or reading set without completion");

   a_held_known: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> held_ff != CMD_UNUSED)
      else $error("transaction running on an unused command");

endmodule
`default_nettype wire

[rtl/tws_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tws_out
// Result register and handshake between the request and result channels.
// ----------------------------------------------------------------------------
module tws_out
   import tws_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   tws_req_if.sink      req_chan,
   tws_rsp_if.source    rsp_chan,
   input  wire rsp_type rsp_in,
   output logic         accept
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type result_ff;

   // Take an item whenever the result slot is free or draining
   assign req_chan.ready = !valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.scl_out       = result_ff.scl_out;
   assign rsp_chan.sda_drive_low = result_ff.sda_drive_low;
   assign rsp_chan.busy_res      = result_ff.busy_res;
   assign rsp_chan.done_res      = result_ff.done_res;
   assign rsp_chan.status        = result_ff.status;
   assign rsp_chan.reading       = result_ff.reading;

endmodule
`default_nettype wire
